// File: src/assert_macros.svh
// Assertion helpers; both expect signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: src/gcr62_pkg.sv
package gcr62_pkg;

  localparam int unsigned AUX_DEPTH  = 86;
  localparam int unsigned AUX_WIDTH  = 6;
  localparam int unsigned AUX_ADDR_W = 7;

  localparam logic [8:0] AUX_COUNT    = 9'd86;
  localparam logic [8:0] GROUP1_START = 9'd172;
  localparam logic [8:0] GROUP2_START = 9'd258;
  localparam logic [8:0] DATA_END     = 9'd342;
  localparam logic [8:0] FIELD_DONE   = 9'd343;

  localparam logic [7:0] TABLE_BASE = 8'h90;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] GROUP_LOW  = 2'd0;
  localparam logic [1:0] GROUP_MID  = 2'd1;
  localparam logic [1:0] GROUP_HIGH = 2'd2;

  // 6-and-2 decode for disk bytes 0x90..0xFF; 0xAA -> 0xFE, 0xD5 -> 0xFF
  localparam logic [7:0] SIX_TWO_MAP [0:111] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
    8'h00, 8'h00, 8'h02, 8'h03, 8'h00, 8'h04, 8'h05, 8'h06,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07, 8'h08,
    8'h00, 8'h00, 8'hFE, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
    8'h00, 8'h00, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13,
    8'h00, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h1B, 8'h00, 8'h1C, 8'h1D, 8'h1E,
    8'h00, 8'h00, 8'h00, 8'h1F, 8'h00, 8'hFF, 8'h20, 8'h21,
    8'h00, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h2A, 8'h2B,
    8'h00, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32,
    8'h00, 8'h00, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h00, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F
  };

  // item held between the decode stage and the output register
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] value;
    logic [7:0] index;
    logic       ok;
    logic [1:0] group;
  } gcr62_item_t;

endpackage

// File: src/gcr62_ram.sv
module gcr62_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 86
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/gcr62_front.sv
module gcr62_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [7:0]                        disk_byte,
  input  logic                              field_start,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              s1_take,
  output gcr62_pkg::gcr62_item_t            s1,
  output logic                              ram_wr_en,
  output logic [gcr62_pkg::AUX_ADDR_W-1:0]  ram_wr_addr,
  output logic [gcr62_pkg::AUX_WIDTH-1:0]   ram_wr_data,
  output logic                              ram_rd_en,
  output logic [gcr62_pkg::AUX_ADDR_W-1:0]  ram_rd_addr
);

  logic [8:0] position;
  logic [8:0] position_next;
  logic [7:0] running_check;
  logic [7:0] running_check_next;

  logic       accept;
  logic [8:0] pos_eff;
  logic [7:0] chk_eff;
  logic [7:0] mapped;
  logic [7:0] chained;
  logic       is_done;
  logic       is_status;
  logic       is_aux;
  logic       is_data;
  logic [1:0] group;
  logic [8:0] group_base;
  logic [8:0] slot_full;
  logic [8:0] index_full;

  assign in_ready = !s1.valid || s1_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos_eff = field_start ? 9'd0 : position;
    chk_eff = field_start ? 8'd0 : running_check;

    if (disk_byte >= gcr62_pkg::TABLE_BASE) begin
      mapped = gcr62_pkg::SIX_TWO_MAP[7'(disk_byte - gcr62_pkg::TABLE_BASE)];
    end else begin
      mapped = 8'd0;
    end
    chained = mapped ^ chk_eff;

    is_done   = pos_eff >= gcr62_pkg::FIELD_DONE;
    is_status = pos_eff == gcr62_pkg::DATA_END;
    is_aux    = pos_eff < gcr62_pkg::AUX_COUNT;
    is_data   = !is_done && !is_status && !is_aux;

    // which two-bit group of the aux word this sector byte uses
    if (pos_eff >= gcr62_pkg::GROUP2_START) begin
      group      = gcr62_pkg::GROUP_HIGH;
      group_base = gcr62_pkg::GROUP2_START;
    end else if (pos_eff >= gcr62_pkg::GROUP1_START) begin
      group      = gcr62_pkg::GROUP_MID;
      group_base = gcr62_pkg::GROUP1_START;
    end else begin
      group      = gcr62_pkg::GROUP_LOW;
      group_base = gcr62_pkg::AUX_COUNT;
    end
    slot_full  = pos_eff - group_base;
    index_full = pos_eff - gcr62_pkg::AUX_COUNT;
  end

  always_comb begin
    position_next      = position;
    running_check_next = running_check;
    if (accept && !is_done) begin
      if (is_status) begin
        position_next = gcr62_pkg::FIELD_DONE;
      end else begin
        position_next      = pos_eff + 9'd1;
        running_check_next = chained;
      end
    end
  end

  assign ram_wr_en   = accept && is_aux;
  assign ram_wr_addr = pos_eff[gcr62_pkg::AUX_ADDR_W-1:0];
  assign ram_wr_data = chained[gcr62_pkg::AUX_WIDTH-1:0];
  assign ram_rd_en   = accept && is_data;
  assign ram_rd_addr = slot_full[gcr62_pkg::AUX_ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= 9'd0;
      running_check <= 8'd0;
      s1.valid      <= 1'b0;
    end else begin
      position      <= position_next;
      running_check <= running_check_next;
      if (accept) begin
        s1.valid <= is_status || is_data;
      end else if (s1_take) begin
        s1.valid <= 1'b0;
      end
    end
    if (accept) begin
      s1.kind  <= is_status ? gcr62_pkg::KIND_STATUS : gcr62_pkg::KIND_DATA;
      s1.value <= is_status ? chk_eff : chained;
      s1.index <= is_status ? 8'd0 : index_full[7:0];
      s1.ok    <= is_status && (mapped == chk_eff);
      s1.group <= group;
    end
  end

endmodule

// File: src/gcr62_out.sv
module gcr62_out (
  input  logic                            clk,
  input  logic                            rst,
  input  gcr62_pkg::gcr62_item_t          s1,
  input  logic [gcr62_pkg::AUX_WIDTH-1:0] aux_word,
  output logic                            s1_take,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            kind,
  output logic [7:0]                      data_byte,
  output logic [7:0]                      byte_index,
  output logic                            checksum_ok
);

  logic [1:0] pair;
  logic [7:0] assembled;

  assign s1_take = s1.valid && (!out_valid || out_ready);

  always_comb begin
    case (s1.group)
      gcr62_pkg::GROUP_LOW: pair = aux_word[1:0];
      gcr62_pkg::GROUP_MID: pair = aux_word[3:2];
      default:              pair = aux_word[5:4];
    endcase
    // pair bits land swapped in the two low bits
    if (s1.kind == gcr62_pkg::KIND_STATUS) begin
      assembled = s1.value;
    end else begin
      assembled = {s1.value[5:0], pair[0], pair[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      kind        <= s1.kind;
      data_byte   <= assembled;
      byte_index  <= s1.index;
      checksum_ok <= s1.ok;
    end
  end

endmodule

// File: src/gcr_six_and_two_sector_decoder.sv
// 6-and-2 GCR data-field decoder for 256-byte sectors.
// Input channel (in_valid/in_ready): one disk byte per item, with
// field_start marking the first of the 343 bytes of a data field.
// Output channel (out_valid/out_ready): bytes 0..85 of a field give no
// item; bytes 86..341 each give one decoded sector byte (kind 0) with its
// byte_index; byte 342 gives a status item (kind 1) with the running
// checksum in data_byte and checksum_ok. Bytes after that give nothing
// until the next field_start.
// An accepted input passes through a decode stage that does the table
// lookup, XOR chain and aux RAM access, then an output register. One
// item is taken per cycle unless the receiver stalls; the aux RAM read
// for a sector byte is issued at accept time so its registered data
// meets the item in the second stage.
// Reset clears position, checksum and both pipeline valids; the aux RAM
// is not cleared. When the receiver stalls, the output register and the
// decode stage each hold one item, then in_ready drops.
`include "assert_macros.svh"

module gcr_six_and_two_sector_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] disk_byte,
  input  logic       field_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [7:0] byte_index,
  output logic       checksum_ok
);

  gcr62_pkg::gcr62_item_t s1;
  logic s1_take;
  logic out_status;

  logic                            ram_wr_en;
  logic [gcr62_pkg::AUX_ADDR_W-1:0] ram_wr_addr;
  logic [gcr62_pkg::AUX_WIDTH-1:0]  ram_wr_data;
  logic                            ram_rd_en;
  logic [gcr62_pkg::AUX_ADDR_W-1:0] ram_rd_addr;
  logic [gcr62_pkg::AUX_WIDTH-1:0]  ram_rd_data;

  gcr62_front u_front (
    .clk         (clk),
    .rst         (rst),
    .disk_byte   (disk_byte),
    .field_start (field_start),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .s1_take     (s1_take),
    .s1          (s1),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr)
  );

  gcr62_ram #(
    .WIDTH (gcr62_pkg::AUX_WIDTH),
    .DEPTH (gcr62_pkg::AUX_DEPTH)
  ) u_aux_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  gcr62_out u_out (
    .clk         (clk),
    .rst         (rst),
    .s1          (s1),
    .aux_word    (ram_rd_data),
    .s1_take     (s1_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data_byte   (data_byte),
    .byte_index  (byte_index),
    .checksum_ok (checksum_ok)
  );

  assign out_status = out_valid && (kind == gcr62_pkg::KIND_STATUS);

  // aux writes and reads belong to different field phases
  `ASSERT_NEVER(a_ram_rw_overlap, ram_wr_en && ram_rd_en, "aux RAM read and write in one cycle")

  // a held decode-stage item must not be overwritten
  `ASSERT_CLK(a_s1_hold, s1.valid && !s1_take |=> $stable(s1), "decode item changed while stalled")

  `ASSERT_CLK(a_status_index, out_status |-> byte_index == 8'd0, "status item with nonzero index")

endmodule
